[rtl/core/client_event_notify_retry_assert.svh]
// ---------------------------------------------------------------------------
// Client event notifier assertion macros
// Shared concurrent assertion helpers, compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef CLIENT_EVENT_NOTIFY_RETRY_ASSERT_SVH
`define CLIENT_EVENT_NOTIFY_RETRY_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define CENR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define CENR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`else

`define CENR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CENR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/cenr_pkg.sv]
// ---------------------------------------------------------------------------
// Client event notifier package
// Shared types, codes and sizes for the notifier controller and datapath.
// ---------------------------------------------------------------------------
package cenr_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int SLOT_W      = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0] NO_ROUND = CNT_W'(MAX_CLIENTS);

    localparam logic [7:0]  RST_OWN_ADDR     = 8'h00;
    localparam logic [15:0] RST_RESP_TIMEOUT = 16'd100;
    localparam logic [15:0] RST_RETRY_GAP    = 16'd200;
    localparam logic [15:0] RST_RESTART      = 16'd500;
    localparam logic [7:0]  RST_INVALID_ADDR = 8'hff;

    typedef enum logic [1:0] {
        OP_POLL,
        OP_CONFIRM,
        OP_CLEAR,
        OP_APPEND
    } t_op;

    typedef enum logic [1:0] {
        PH_PENDING,
        PH_WAIT,
        PH_DONE,
        PH_GIVEN_UP
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDR,
        CFG_RESP_TIMEOUT,
        CFG_RETRY_GAP,
        CFG_RESTART_PERIOD,
        CFG_INVALID_ADDR
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SCAN_SWEEP,
        SCAN_NEXT,
        SCAN_CONF
    } t_scan_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_GATE,
        ST_SERVE,
        ST_SCAN,
        ST_CONFIRM,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_op         cmd;
        logic [15:0] now_ms;
        logic        bus_ok;
        logic [7:0]  from_addr;
        logic [7:0]  to_addr;
        logic [7:0]  client_addr;
        logic [7:0]  max_retry;
    } t_req;

    typedef struct packed {
        logic             sent;
        logic [7:0]       dest_addr;
        logic [CNT_W-1:0] current_slot;
        logic [CNT_W-1:0] client_count;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  retry_limit;
        logic [7:0]  retry_count;
        t_phase      phase;
        logic [15:0] stamp;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       clear;
        logic       append;
        logic       conf_start;
        logic       round_start;
        logic       gate_open;
        logic       serve;
        logic       scan_run;
        t_scan_mode mode;
        logic       take_hit;
        logic       take_end;
        logic       out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic len_zero;
        logic restart_due;
        logic conf_match;
        logic gate_ok;
        logic advance;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/cenr_dp.sv]
// ---------------------------------------------------------------------------
// Client event notifier datapath
// Slot memory, list and round registers, slot scan engine, result register.
// ---------------------------------------------------------------------------
`include "client_event_notify_retry_assert.svh"

module cenr_dp import cenr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_req                  i_in_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_rsp                  o_out_rsp
);

    function automatic logic [15:0] elapsed(input logic [15:0] now, input logic [15:0] then_ms);
        return now - then_ms;
    endfunction

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(a) + CNT_W'(1);
        return (nx >= len) ? '0 : nx[SLOT_W-1:0];
    endfunction

    // configuration
    logic [7:0]  r_own_addr;
    logic [15:0] r_resp_timeout;
    logic [15:0] r_retry_gap;
    logic [15:0] r_restart;
    logic [7:0]  r_invalid_addr;

    // list and round state
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_cursor;
    logic             r_gap;
    logic [15:0]      r_gap_stamp;
    logic [15:0]      r_round_stamp;

    // request in work and result
    t_req             r_item;
    logic             r_sent;
    logic [7:0]       r_dest;
    logic             r_self_uns;
    logic             r_out_valid;
    t_rsp             r_out;

    // slot memory and scan engine
    t_slot            r_mem [MAX_CLIENTS];
    t_slot            r_rd_data;
    logic [SLOT_W-1:0] r_rd_idx;
    logic [SLOT_W-1:0] r_ra;
    logic [CNT_W-1:0] r_rem;
    logic             r_rv;

    logic [SLOT_W-1:0] s;
    t_slot            sv_slot;
    logic             sv_adv;
    logic             sv_sent;
    logic             sv_uns;
    logic             scan_hit;
    logic             app_ok;
    logic             mem_we;
    logic [SLOT_W-1:0] mem_wa;
    t_slot            mem_wd;
    logic             rd_en;
    logic [SLOT_W-1:0] rd_a;

    assign s = r_cursor[SLOT_W-1:0];
    assign app_ok = (r_item.client_addr != r_invalid_addr) && (r_len < CNT_W'(MAX_CLIENTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr     <= RST_OWN_ADDR;
            r_resp_timeout <= RST_RESP_TIMEOUT;
            r_retry_gap    <= RST_RETRY_GAP;
            r_restart      <= RST_RESTART;
            r_invalid_addr <= RST_INVALID_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_ADDR:       r_own_addr     <= i_cfg_wdata[7:0];
                CFG_RESP_TIMEOUT:   r_resp_timeout <= i_cfg_wdata;
                CFG_RETRY_GAP:      r_retry_gap    <= i_cfg_wdata;
                CFG_RESTART_PERIOD: r_restart      <= i_cfg_wdata;
                CFG_INVALID_ADDR:   r_invalid_addr <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // serve the slot under the cursor
    always_comb begin
        sv_slot = r_rd_data;
        sv_adv  = 1'b1;
        sv_sent = 1'b0;
        case (r_rd_data.phase)
            PH_PENDING: begin
                if (r_item.bus_ok) begin
                    sv_sent       = 1'b1;
                    sv_slot.phase = PH_WAIT;
                    sv_slot.stamp = r_item.now_ms;
                end else begin
                    sv_adv = 1'b0;
                end
            end
            PH_WAIT: begin
                if (elapsed(r_item.now_ms, r_rd_data.stamp) >= r_resp_timeout) begin
                    if (r_rd_data.retry_count < r_rd_data.retry_limit) begin
                        sv_slot.retry_count = r_rd_data.retry_count + 8'd1;
                        sv_slot.phase       = PH_PENDING;
                        sv_adv              = 1'b0;
                    end else begin
                        sv_slot.phase = PH_GIVEN_UP;
                    end
                end
            end
            default: ;
        endcase
        sv_uns = (sv_slot.phase == PH_PENDING) || (sv_slot.phase == PH_WAIT);
    end

    always_comb begin
        case (i_cmd.mode)
            SCAN_NEXT: scan_hit = r_rv && ((r_rd_data.phase == PH_PENDING) ||
                                           (r_rd_data.phase == PH_WAIT));
            SCAN_CONF: scan_hit = r_rv && (r_rd_data.address == r_item.from_addr) &&
                                  (r_rd_data.phase == PH_WAIT);
            default:   scan_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_status.op          = r_item.cmd;
        o_status.len_zero    = (r_len == '0);
        o_status.restart_due = elapsed(r_item.now_ms, r_round_stamp) >= r_restart;
        o_status.conf_match  = (r_item.to_addr == r_own_addr);
        o_status.gate_ok     = (r_cursor < r_len) &&
                               !(r_gap && (elapsed(r_item.now_ms, r_gap_stamp) < r_retry_gap));
        o_status.advance     = sv_adv;
        o_status.scan_hit    = scan_hit;
        o_status.scan_end    = (r_rem == '0) && !r_rv;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    // single write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_rd_idx;
        mem_wd = r_rd_data;
        if (i_cmd.append && app_ok) begin
            mem_we = 1'b1;
            mem_wa = r_len[SLOT_W-1:0];
            mem_wd = '{address: r_item.client_addr, retry_limit: r_item.max_retry,
                       retry_count: 8'd0, phase: PH_PENDING, stamp: 16'd0};
        end else if (i_cmd.serve) begin
            mem_we = 1'b1;
            mem_wa = s;
            mem_wd = sv_slot;
        end else if (i_cmd.scan_run && (i_cmd.mode == SCAN_SWEEP) && r_rv) begin
            mem_we             = 1'b1;
            mem_wd.phase       = PH_PENDING;
            mem_wd.retry_count = 8'd0;
        end else if (i_cmd.scan_run && (i_cmd.mode == SCAN_CONF) && scan_hit) begin
            mem_we       = 1'b1;
            mem_wd.phase = PH_DONE;
        end
    end

    assign rd_en = i_cmd.gate_open || (i_cmd.scan_run && (r_rem != '0));
    assign rd_a  = i_cmd.gate_open ? s : r_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_a];
        end
    end

    // scan engine: one read issued per cycle, checked the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv  <= 1'b0;
            r_rem <= '0;
        end else if (i_cmd.round_start || i_cmd.conf_start) begin
            r_ra  <= '0;
            r_rem <= r_len;
            r_rv  <= 1'b0;
        end else if (i_cmd.serve) begin
            r_ra  <= wrap_inc(s, r_len);
            r_rem <= r_len - CNT_W'(1);
            r_rv  <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_rv <= (r_rem != '0);
            if (r_rem != '0) begin
                r_rd_idx <= r_ra;
                r_ra     <= wrap_inc(r_ra, r_len);
                r_rem    <= r_rem - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_cursor      <= NO_ROUND;
            r_gap         <= 1'b0;
            r_gap_stamp   <= '0;
            r_round_stamp <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_len    <= '0;
                r_cursor <= NO_ROUND;
                r_gap    <= 1'b0;
            end
            if (i_cmd.append && app_ok) begin
                r_len <= r_len + CNT_W'(1);
            end
            if (i_cmd.round_start) begin
                r_cursor      <= '0;
                r_gap         <= 1'b0;
                r_round_stamp <= r_item.now_ms;
            end
            if (i_cmd.gate_open) begin
                r_gap <= 1'b0;
            end
            if (i_cmd.take_hit) begin
                r_cursor <= CNT_W'(r_rd_idx);
                if (r_rd_idx <= s) begin
                    r_gap       <= 1'b1;
                    r_gap_stamp <= r_item.now_ms;
                end
            end
            if (i_cmd.take_end) begin
                if (r_self_uns) begin
                    r_gap       <= 1'b1;
                    r_gap_stamp <= r_item.now_ms;
                end else begin
                    r_cursor <= NO_ROUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_req;
            r_sent <= 1'b0;
            r_dest <= 8'd0;
        end else if (i_cmd.serve) begin
            r_sent     <= sv_sent;
            r_dest     <= sv_sent ? r_rd_data.address : 8'd0;
            r_self_uns <= sv_uns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= '{sent: r_sent, dest_addr: r_dest, current_slot: r_cursor,
                       client_count: r_len};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `CENR_ASSERT(a_cursor_in_list, i_clk, i_rst_n, (r_cursor == NO_ROUND) || (r_cursor < r_len), "cursor outside list")
    `CENR_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= CNT_W'(MAX_CLIENTS), "list length over capacity")
    `CENR_ASSERT_IMPL(a_gap_needs_round, i_clk, i_rst_n, r_gap, r_cursor != NO_ROUND)

endmodule

[rtl/core/cenr_ctrl.sv]
// ---------------------------------------------------------------------------
// Client event notifier controller
// Sequences one request through dispatch, round sweep, serve and scans.
// ---------------------------------------------------------------------------
module cenr_ctrl import cenr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_POLL: begin
                        if (i_status.len_zero)         n_state = ST_FINISH;
                        else if (i_status.restart_due) n_state = ST_SWEEP;
                        else                           n_state = ST_GATE;
                    end
                    OP_CONFIRM: begin
                        if (i_status.conf_match && !i_status.len_zero) n_state = ST_CONFIRM;
                        else                                          n_state = ST_FINISH;
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_SWEEP: begin
                if (i_status.scan_end) n_state = ST_GATE;
            end
            ST_GATE: begin
                n_state = i_status.gate_ok ? ST_SERVE : ST_FINISH;
            end
            ST_SERVE: begin
                n_state = i_status.advance ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN, ST_CONFIRM: begin
                if (i_status.scan_hit || i_status.scan_end) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = SCAN_NEXT;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_CLEAR:   o_cmd.clear  = 1'b1;
                    OP_APPEND:  o_cmd.append = 1'b1;
                    OP_CONFIRM: o_cmd.conf_start = i_status.conf_match && !i_status.len_zero;
                    default:    o_cmd.round_start = !i_status.len_zero && i_status.restart_due;
                endcase
            end
            ST_SWEEP: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.mode     = SCAN_SWEEP;
            end
            ST_GATE: begin
                o_cmd.gate_open = i_status.gate_ok;
            end
            ST_SERVE: begin
                o_cmd.serve = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.take_hit = i_status.scan_hit;
                o_cmd.take_end = !i_status.scan_hit && i_status.scan_end;
            end
            ST_CONFIRM: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.mode     = SCAN_CONF;
            end
            ST_FINISH: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/client_event_notify_retry.sv]
// ---------------------------------------------------------------------------
// Client event notifier with retry
// Keeps a compacted list of up to MAX_CLIENTS (16) client addresses, each
// with a retry limit, retry count, phase and 16-bit millisecond timestamp.
// A poll request serves the slot under the cursor: a pending client gets an
// event request when the bus accepts it, a client waiting past the response
// timeout is resent until its retry limit, then given up. Whenever the
// restart period has passed since the last round start, every client goes
// back to pending and the cursor restarts at slot 0; after the cursor wraps,
// the retry gap must pass before the next send. Confirm requests addressed to
// this node mark the first waiting slot of the sender done; clear empties the
// list; append adds a client unless the list is full or the address is the
// invalid one. All time compares wrap modulo 65536. Every request gives one
// result. One request is in work at a time; the result register lets the next
// request enter while a result waits. Slot state lives in one memory with one
// write and one registered read port, and every slot walk reads one slot per
// cycle, so confirm and poll time grows with the clients in the list; a poll
// takes longest when a round restarts and the following slot search runs the
// whole list. Configuration must be written through a plain write port only
// while the block idles; the block itself does not enforce this. Registers
// are own address, response timeout, retry gap, restart period and invalid
// address at indexes 0 to 4.
// ---------------------------------------------------------------------------
module client_event_notify_retry import cenr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_req,

    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rsp                  o_out_rsp
);

    // command and status between the sequencer and the datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Controller: request sequencing. Stall is high whenever a request is in
    // work; the result register in the datapath decouples the output side.
    cenr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath: configuration, slot memory, cursor/round/gap state, scan
    // engine and the result register.
    cenr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_req    (i_in_req),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule
